[rtl/pdd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdd_pkg: shared types and constants of the polyline distance decimator
// Widths of the vertex index, output ids, remap table entries and the
// decision record passed from the distance front end to the remap back end.
// ----------------------------------------------------------------------------
package pdd_pkg;

  // source point table
  localparam int MAX_POINTS = 4096;
  localparam int IDX_W      = $clog2(MAX_POINTS);

  // compacted output ids, counter saturates at the id limit
  localparam int ID_W   = 12;
  localparam int NEXT_W = ID_W + 1;
  localparam logic [NEXT_W-1:0] ID_LIMIT = NEXT_W'(4096);

  // set epoch stored next to each remap entry in place of a seen flag
  localparam int EPOCH_W = 10;

  // distance arithmetic: 16-bit magnitudes, exact squares
  localparam int SMOOTH_W = 16;
  localparam int SQ_W     = 2 * SMOOTH_W;
  localparam int SUM_W    = SQ_W + 2;

  // decoupling queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  // result channel payload
  localparam int OUT_DATA_W = ((ID_W + 7) / 8) * 8;

  typedef struct packed {
    logic             new_set;
    logic             line_end;
    logic             keep;
    logic [IDX_W-1:0] idx;
  } dec_item_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [ID_W-1:0]    id;
  } remap_ent_t;

endpackage
`default_nettype wire

[rtl/polyline_distance_decimator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_distance_decimator: radial distance polyline simplification
// Keeps line ends and every vertex at least smooth_length from the last kept
// vertex, and maps kept source points to compacted output ids.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake         payload
// in_*      slave      tvalid / tready   tdata: point, coords; tuser: flags; tlast
// out_*     master     tvalid / tready   tdata: new_id; tuser: flags; tlast
// cfg_*     write      cfg_we            cfg_wdata: smooth_length
//
// one vertex per cycle sustained when no stall holds it; input to result passes
// accept, square, decide, queue, table read and output register
// after reset all 4096 remap table entries are cleared with in_tready low
// a new_set transaction at the top set epoch (1023) starts another table clear
// while the remap stage holds; the queue keeps taking input until full
// either side may stall at any time; the front decision loop and the remap
// table run independently across the four-entry decision queue
//
module polyline_distance_decimator #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,

  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // point_index[11:0], coord_x, coord_y, coord_z (COORD_BITS each), zero pad
  input  wire logic [((pdd_pkg::IDX_W + 3 * COORD_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // new_set, first_in_line
  input  wire logic [1:0]                        in_tuser,
  // last_in_line
  input  wire logic                              in_tlast,

  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // new_id[11:0], zero pad
  output logic [pdd_pkg::OUT_DATA_W-1:0]         out_tdata,
  // keep, is_new_point
  output logic [1:0]                             out_tuser,
  // line_end
  output logic                                   out_tlast,

  input  wire logic                              cfg_we,
  input  wire logic [pdd_pkg::SMOOTH_W-1:0]      cfg_wdata
);
  import pdd_pkg::*;

  localparam int X_LSB = IDX_W;
  localparam int Y_LSB = IDX_W + COORD_BITS;
  localparam int Z_LSB = IDX_W + 2 * COORD_BITS;

  // squared smoothing length, squared once at the register write
  logic [SQ_W-1:0]   len2_r;

  logic              front_ready;
  logic              init_busy;
  logic              q_full;
  logic              push_valid;
  dec_item_t         push_item;
  logic              q_valid;
  dec_item_t         q_item;
  logic              q_pop;
  logic              res_keep;
  logic              res_fresh;
  logic [ID_W-1:0]   res_id;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len2_r <= '0;
    end else if (cfg_we) begin
      len2_r <= cfg_wdata * cfg_wdata;
    end
  end

  // no input during the initial table clear
  assign in_tready = front_ready && !init_busy;

  pdd_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid && !init_busy),
    .in_ready   (front_ready),
    .in_new_set (in_tuser[0]),
    .in_first   (in_tuser[1]),
    .in_last    (in_tlast),
    .in_idx     (in_tdata[IDX_W-1:0]),
    .in_x       (in_tdata[X_LSB +: COORD_BITS]),
    .in_y       (in_tdata[Y_LSB +: COORD_BITS]),
    .in_z       (in_tdata[Z_LSB +: COORD_BITS]),
    .len2       (len2_r),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  pdd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  pdd_remap u_remap (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_keep     (res_keep),
    .out_fresh    (res_fresh),
    .out_id       (res_id),
    .out_line_end (out_tlast),
    .init_busy    (init_busy)
  );

  // result packing, id in the low bits
  assign out_tdata = OUT_DATA_W'(res_id);
  assign out_tuser = {res_fresh, res_keep};

endmodule
`default_nettype wire

[rtl/pdd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdd_front: keep decision for incoming vertices
// Two stages: differences and squares against the two possible last kept
// vertices, then sum, compare with the squared length and select.
// ----------------------------------------------------------------------------
module pdd_front #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_new_set,
  input  wire logic                           in_first,
  input  wire logic                           in_last,
  input  wire logic [pdd_pkg::IDX_W-1:0]      in_idx,
  input  wire logic signed [COORD_BITS-1:0]   in_x,
  input  wire logic signed [COORD_BITS-1:0]   in_y,
  input  wire logic signed [COORD_BITS-1:0]   in_z,
  input  wire logic [pdd_pkg::SQ_W-1:0]       len2,
  input  wire logic                           q_full,
  output logic                                push_valid,
  output pdd_pkg::dec_item_t                  push_item
);
  import pdd_pkg::*;

  localparam int DW = COORD_BITS + 1;

  logic                         adv;
  logic                         accept;

  // stage a: accepted vertex
  logic                         a_valid_r;
  logic                         a_new_set_r;
  logic                         a_first_r;
  logic                         a_last_r;
  logic [IDX_W-1:0]             a_idx_r;
  logic signed [COORD_BITS-1:0] a_crd_r [3];

  // stage b: squares against both candidates
  logic                         b_valid_r;
  logic                         b_new_set_r;
  logic                         b_first_r;
  logic                         b_last_r;
  logic [IDX_W-1:0]             b_idx_r;
  logic signed [COORD_BITS-1:0] b_crd_r [3];
  logic [SQ_W-1:0]              b_sq0_r [3];
  logic [SQ_W-1:0]              b_sq1_r [3];
  logic [2:0]                   b_big0_r;
  logic [2:0]                   b_big1_r;
  logic                         b_use_c1_r;

  // last kept vertex, final for everything older than stage b
  logic signed [COORD_BITS-1:0] prev_r [3];

  logic [SQ_W-1:0]              sq0 [3];
  logic [SQ_W-1:0]              sq1 [3];
  logic [2:0]                   big0;
  logic [2:0]                   big1;
  logic [SUM_W-1:0]             sum0;
  logic [SUM_W-1:0]             sum1;
  logic                         far0;
  logic                         far1;
  logic                         b_keep;

  assign adv      = !(b_valid_r && q_full);
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  // candidate 0: committed last kept vertex, candidate 1: vertex in stage b
  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic signed [DW-1:0] d0;
    logic signed [DW-1:0] d1;
    logic [DW-1:0]        m0;
    logic [DW-1:0]        m1;
    logic [32:0]          e0;
    logic [32:0]          e1;

    assign d0 = {a_crd_r[k][COORD_BITS-1], a_crd_r[k]} -
                {prev_r[k][COORD_BITS-1], prev_r[k]};
    assign d1 = {a_crd_r[k][COORD_BITS-1], a_crd_r[k]} -
                {b_crd_r[k][COORD_BITS-1], b_crd_r[k]};
    assign m0 = d0[DW-1] ? DW'(-d0) : DW'(d0);
    assign m1 = d1[DW-1] ? DW'(-d1) : DW'(d1);
    assign e0 = 33'(m0);
    assign e1 = 33'(m1);
    // a gap of 65536 or more is always far enough
    assign big0[k] = |e0[32:16];
    assign big1[k] = |e1[32:16];
    assign sq0[k]  = e0[15:0] * e0[15:0];
    assign sq1[k]  = e1[15:0] * e1[15:0];
  end

  always_comb begin
    sum0   = SUM_W'(b_sq0_r[0]) + SUM_W'(b_sq0_r[1]) + SUM_W'(b_sq0_r[2]);
    sum1   = SUM_W'(b_sq1_r[0]) + SUM_W'(b_sq1_r[1]) + SUM_W'(b_sq1_r[2]);
    far0   = (|b_big0_r) || (sum0 >= SUM_W'(len2));
    far1   = (|b_big1_r) || (sum1 >= SUM_W'(len2));
    b_keep = b_first_r || b_last_r || (b_use_c1_r ? far1 : far0);
  end

  assign push_valid         = b_valid_r && adv;
  assign push_item.new_set  = b_new_set_r;
  assign push_item.line_end = b_last_r;
  assign push_item.keep     = b_keep;
  assign push_item.idx      = b_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r  <= 1'b0;
      b_valid_r  <= 1'b0;
      b_use_c1_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        prev_r[k] <= '0;
      end
    end else if (adv) begin
      a_valid_r  <= accept;
      b_valid_r  <= a_valid_r;
      // the item entering b compares against the one leaving b if that was kept
      b_use_c1_r <= b_valid_r && b_keep;
      if (b_valid_r && b_keep) begin
        for (int k = 0; k < 3; k++) begin
          prev_r[k] <= b_crd_r[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_new_set_r <= in_new_set;
      a_first_r   <= in_first;
      a_last_r    <= in_last;
      a_idx_r     <= in_idx;
      a_crd_r[0]  <= in_x;
      a_crd_r[1]  <= in_y;
      a_crd_r[2]  <= in_z;
    end
    if (adv) begin
      b_new_set_r <= a_new_set_r;
      b_first_r   <= a_first_r;
      b_last_r    <= a_last_r;
      b_idx_r     <= a_idx_r;
      b_big0_r    <= big0;
      b_big1_r    <= big1;
      for (int k = 0; k < 3; k++) begin
        b_crd_r[k] <= a_crd_r[k];
        b_sq0_r[k] <= sq0[k];
        b_sq1_r[k] <= sq1[k];
      end
    end
  end

  // line ends always become the new reference vertex
  a_end_moves_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && b_valid_r && (b_first_r || b_last_r)) |=>
      (prev_r[0] == $past(b_crd_r[0]) && prev_r[1] == $past(b_crd_r[1]) &&
       prev_r[2] == $past(b_crd_r[2])))
    else $error("line end vertex did not update reference");

  // the reference only moves when a kept vertex leaves stage b
  a_prev_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && b_valid_r && b_keep) |=>
      ($stable(prev_r[0]) && $stable(prev_r[1]) && $stable(prev_r[2])))
    else $error("reference vertex moved without a kept vertex");

endmodule
`default_nettype wire

[rtl/pdd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdd_queue: decision queue
// Small register fifo that lets the front end and the remap back end stall
// independently.
// ----------------------------------------------------------------------------
module pdd_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  input  pdd_pkg::dec_item_t      push_item,
  output logic                    full,
  output logic                    pop_valid,
  output pdd_pkg::dec_item_t      pop_item,
  input  wire logic               pop
);
  import pdd_pkg::*;

  dec_item_t         slot_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full      = (count_r == QCNT_W'(Q_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> (count_r < QCNT_W'(Q_DEPTH)))
    else $error("decision pushed into a full queue");

endmodule
`default_nettype wire

[rtl/pdd_remap.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdd_remap: output id assignment
// Remap table with a set epoch per entry; an entry is seen when its epoch is
// the current one. Clears the table after reset and on epoch wrap.
// ----------------------------------------------------------------------------
module pdd_remap (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  pdd_pkg::dec_item_t         q_item,
  output logic                       q_pop,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic                       out_keep,
  output logic                       out_fresh,
  output logic [pdd_pkg::ID_W-1:0]   out_id,
  output logic                       out_line_end,
  output logic                       init_busy
);
  import pdd_pkg::*;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  state_t             st_r;
  logic [IDX_W-1:0]   clr_addr_r;
  logic               boot_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [NEXT_W-1:0]  next_id_r;
  logic               r2_valid_r;
  dec_item_t          r2_item_r;
  remap_ent_t         mem_q_r;
  logic               fwd_valid_r;
  logic [IDX_W-1:0]   fwd_addr_r;
  remap_ent_t         fwd_data_r;
  logic               out_valid_r;
  logic               out_keep_r;
  logic               out_fresh_r;
  logic [ID_W-1:0]    out_id_r;
  logic               out_line_end_r;

  remap_ent_t         table_mem [MAX_POINTS];

  logic               wrap;
  logic               do_item;
  logic [EPOCH_W-1:0] ep;
  logic [NEXT_W-1:0]  nid;
  remap_ent_t         rd;
  logic               seen;
  logic               fresh;
  logic [ID_W-1:0]    id;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  remap_ent_t         wr_data;

  always_comb begin
    wrap    = r2_item_r.new_set && (epoch_r == '1);
    do_item = (st_r == ST_RUN) && r2_valid_r && !wrap && (!out_valid_r || out_ready);
    q_pop   = (st_r == ST_RUN) && q_valid && (!r2_valid_r || do_item);
    ep      = r2_item_r.new_set ? (epoch_r + EPOCH_W'(1)) : epoch_r;
    nid     = r2_item_r.new_set ? '0 : next_id_r;
    // last write may have landed in the same cycle as this entry's read
    rd      = (fwd_valid_r && fwd_addr_r == r2_item_r.idx) ? fwd_data_r : mem_q_r;
    seen    = !r2_item_r.new_set && (rd.epoch == epoch_r);
    fresh   = 1'b0;
    id      = '0;
    if (r2_item_r.keep) begin
      if (seen) begin
        id = rd.id;
      end else if (nid < ID_LIMIT) begin
        id    = nid[ID_W-1:0];
        fresh = 1'b1;
      end else begin
        id = '1;
      end
    end
    wr_en   = (st_r == ST_CLEAR) || (do_item && fresh);
    wr_addr = (st_r == ST_CLEAR) ? clr_addr_r : r2_item_r.idx;
    wr_data = (st_r == ST_CLEAR) ? remap_ent_t'('0) : remap_ent_t'({ep, id});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_addr_r  <= '0;
      boot_r      <= 1'b1;
      epoch_r     <= EPOCH_W'(1);
      next_id_r   <= '0;
      r2_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (st_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + IDX_W'(1);
          if (clr_addr_r == '1) begin
            st_r        <= ST_RUN;
            boot_r      <= 1'b0;
            // cleared entries hold epoch zero
            epoch_r     <= EPOCH_W'(1);
            fwd_valid_r <= 1'b0;
          end
        end
        ST_RUN: begin
          if (r2_valid_r && wrap) begin
            st_r <= ST_CLEAR;
          end
        end
        default: st_r <= ST_CLEAR;
      endcase

      if (do_item) begin
        epoch_r   <= ep;
        next_id_r <= nid + NEXT_W'(fresh);
      end
      if (do_item && fresh) begin
        fwd_valid_r <= 1'b1;
        fwd_addr_r  <= r2_item_r.idx;
        fwd_data_r  <= wr_data;
      end

      if (q_pop) begin
        r2_valid_r <= 1'b1;
        r2_item_r  <= q_item;
      end else if (do_item) begin
        r2_valid_r <= 1'b0;
      end

      if (do_item) begin
        out_valid_r    <= 1'b1;
        out_keep_r     <= r2_item_r.keep;
        out_fresh_r    <= fresh;
        out_id_r       <= id;
        out_line_end_r <= r2_item_r.line_end;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // remap table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (q_pop) begin
      mem_q_r <= table_mem[q_item.idx];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_keep     = out_keep_r;
  assign out_fresh    = out_fresh_r;
  assign out_id       = out_id_r;
  assign out_line_end = out_line_end_r;
  assign init_busy    = boot_r;

  a_id_cap: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r <= ID_LIMIT)
    else $error("id counter beyond its limit");

  a_fresh_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_item && fresh) |=> (next_id_r == $past(nid) + NEXT_W'(1)))
    else $error("new id issued without counter advance");

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLEAR) |-> (!do_item && !q_pop))
    else $error("item handled during table clear");

endmodule
`default_nettype wire
